>>> hw/rtl/pgm_pkg.sv
package pgm_pkg;

    localparam int VW        = 32;
    localparam int FB        = 16;
    localparam int GW        = 5;
    localparam int DVD_W     = GW + 2 * FB;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int ACC_W     = 2 * VW + 2;

    localparam logic [GW-1:0] GAIN_MAX   = GW'(20);
    localparam logic [GW-1:0] GAIN_RESET = GW'(2);

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [1:0] ITEM_KP = 2'd0;
    localparam logic [1:0] ITEM_KI = 2'd1;
    localparam logic [1:0] ITEM_KD = 2'd2;

    localparam logic [VW-1:0] PERIOD_RESET = VW'(655);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_COEF  = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_FLUSH = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic logic signed [VW-1:0] sat(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            sat = hi[VW-1:0];
        end else if (x < lo) begin
            sat = lo[VW-1:0];
        end else begin
            sat = x[VW-1:0];
        end
    endfunction

    function automatic logic signed [VW-1:0] gain_value(input logic [GW-1:0] g);
        gain_value = {{(VW-GW-FB+1){1'b0}}, g, {(FB-1){1'b0}}};
    endfunction

endpackage

>>> hw/rtl/pid_controller_with_gain_menu_core.sv
// PID speed controller with a three-gain menu (Tustin, velocity form), Q16.16.
// Every accepted input beat gives exactly one result beat. In the menu, set steps
// through kp/ki/kd and plus/minus move the selected gain by 0.5 within 0..10; hold
// goes to standby. From standby set starts running; each running beat gives
// u = a*e + b*e1 + c*e2 + u2. Menu beats and hold/set while running go straight to
// the result; a running control sample runs three products through one shared
// 32x32 multiplier, then a flush and the final sum; whenever coefficients are
// rebuilt (hold in the menu, any standby beat), the 37-step bit-serial divider
// forms 2Kd/T before the coefficients are registered. A result that cannot yet be
// posted to the output register delays the next input accept. The block takes one
// beat at a time; a finished result sits in an output register, so the next input
// beat can be taken while it waits. Configuration (index 0 target, 1 sample
// period) is written through its own channel, always ready; the user must write
// it only while the block is idle, as the block itself does not enforce this.
module pid_controller_with_gain_menu_core
    import pgm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [VW-1:0]        i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_plus_pressed,
    input  logic                 i_minus_pressed,
    input  logic                 i_set_pressed,
    input  logic                 i_hold_pressed,
    input  logic signed [VW-1:0] i_measured_velocity,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_operation,
    output logic                 o_is_running,
    output logic [1:0]           o_gain_selected,
    output logic signed [VW-1:0] o_shown_value
);
    t_state r_state;

    // config registers
    logic signed [VW-1:0] r_target;
    logic [VW-1:0]        r_period;

    // controller state
    logic                 r_op;
    logic                 r_run;
    logic [1:0]           r_item;
    logic [GW-1:0]        r_gain [3];
    logic signed [VW-1:0] r_coef [3];
    logic signed [VW-1:0] r_err  [3];
    logic signed [VW-1:0] r_eff  [3];
    logic signed [VW-1:0] r_shown;
    logic [1:0]           r_cnt;

    // output register
    logic                 r_out_valid;
    logic                 r_o_op;
    logic                 r_o_run;
    logic [1:0]           r_o_item;
    logic signed [VW-1:0] r_o_shown;

    logic                 accept;
    logic                 post_res;
    logic                 div_start;
    logic                 div_done;
    logic [DVD_W-1:0]     quo;
    logic [VW-1:0]        t_eff;
    logic [1:0]           item_next;
    logic [GW-1:0]        gain_cur;
    logic [GW-1:0]        gain_new;
    logic signed [VW-1:0] err_new;
    logic                 mac_clr;
    logic                 mac_en;
    logic signed [VW-1:0] mac_a;
    logic signed [VW-1:0] mac_b;
    logic signed [ACC_W-1:0] acc;

    // coefficient and effort math
    logic [VW+GW-1:0]     gi_t;
    logic signed [39:0]   cd, cp, ci, ca, cb, cc;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [63:0]   u_sum;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign t_eff       = (r_period == '0) ? VW'(1) : r_period;
    // result beat posted when the output register is free or draining
    assign post_res    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        item_next = (r_item == ITEM_KD) ? ITEM_KP : r_item + 2'd1;
        gain_cur  = r_gain[r_item];
        gain_new  = gain_cur;
        if (i_plus_pressed) begin
            if (gain_cur < GAIN_MAX) gain_new = gain_cur + 1'b1;
        end else if (i_minus_pressed) begin
            if (gain_cur != '0) gain_new = gain_cur - 1'b1;
        end
        err_new = sat(64'(r_target) - 64'(i_measured_velocity));
    end

    // divider runs on hold in the menu and on every standby beat
    assign div_start = accept && ((!r_op && i_hold_pressed) || (r_op && !r_run));

    pgm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_gain[ITEM_KD], {(2*FB){1'b0}}}),
        .i_divisor  (t_eff),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign mac_clr = accept;
    assign mac_en  = (r_state == S_MAC);
    always_comb begin
        mac_a = r_coef[0];
        mac_b = r_err[0];
        case (r_cnt)
            2'd1:    begin mac_a = r_coef[1]; mac_b = r_err[1]; end
            2'd2:    begin mac_a = r_coef[2]; mac_b = r_err[2]; end
            default: begin mac_a = r_coef[0]; mac_b = r_err[0]; end
        endcase
    end

    pgm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mac_clr),
        .i_en    (mac_en),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    always_comb begin
        gi_t   = (VW+GW)'(r_gain[ITEM_KI]) * (VW+GW)'(t_eff);
        cd     = 40'(quo);
        cp     = 40'(gain_value(r_gain[ITEM_KP]));
        ci     = 40'(gi_t[VW+GW-1:2]);
        ca     = cd + cp + ci;
        cb     = (ci <<< 1) - (cd <<< 1);
        cc     = cd - cp + ci;
        // floor shift of the exact sum, then add u2
        acc_sh = acc >>> FB;
        u_sum  = acc_sh[63:0] + 64'(r_eff[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_period    <= PERIOD_RESET;
            r_op        <= 1'b0;
            r_run       <= 1'b0;
            r_item      <= ITEM_KP;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= GAIN_RESET;
                r_coef[k] <= '0;
                r_err[k]  <= '0;
                r_eff[k]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TARGET: r_target <= i_cfg_data;
                    REG_PERIOD: r_period <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (post_res) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!r_op) begin
                            if (i_hold_pressed) begin
                                r_op    <= 1'b1;
                                r_run   <= 1'b0;
                                r_shown <= r_target;
                                r_state <= S_DIV;
                            end else if (i_set_pressed) begin
                                r_item  <= item_next;
                                r_shown <= gain_value(r_gain[item_next]);
                                r_state <= S_DONE;
                            end else begin
                                r_gain[r_item] <= gain_new;
                                r_shown <= gain_value(gain_new);
                                r_state <= S_DONE;
                            end
                        end else if (!r_run) begin
                            r_state <= S_DIV;
                            if (i_hold_pressed) begin
                                r_op    <= 1'b0;
                                r_item  <= ITEM_KP;
                                r_shown <= gain_value(r_gain[ITEM_KP]);
                                for (int k = 0; k < 3; k++) begin
                                    r_err[k] <= '0;
                                    r_eff[k] <= '0;
                                end
                            end else if (i_set_pressed) begin
                                r_run   <= 1'b1;
                                r_shown <= r_eff[0];
                            end else begin
                                r_shown <= r_target;
                            end
                        end else begin
                            if (i_hold_pressed || i_set_pressed) begin
                                if (i_hold_pressed) begin
                                    r_op    <= 1'b0;
                                    r_item  <= ITEM_KP;
                                    r_shown <= gain_value(r_gain[ITEM_KP]);
                                end else begin
                                    r_run   <= 1'b0;
                                    r_shown <= r_target;
                                end
                                for (int k = 0; k < 3; k++) begin
                                    r_err[k] <= '0;
                                    r_eff[k] <= '0;
                                end
                                r_state <= S_DONE;
                            end else begin
                                r_err[2] <= r_err[1];
                                r_err[1] <= r_err[0];
                                r_err[0] <= err_new;
                                r_eff[2] <= r_eff[1];
                                r_eff[1] <= r_eff[0];
                                r_cnt    <= '0;
                                r_state  <= S_MAC;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) r_state <= S_COEF;
                end
                S_COEF: begin
                    r_coef[0] <= sat(64'(ca));
                    r_coef[1] <= sat(64'(cb));
                    r_coef[2] <= sat(64'(cc));
                    r_state   <= S_DONE;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_eff[0] <= sat(u_sum);
                    r_shown  <= sat(u_sum);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (post_res) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, loaded as the beat is posted
    always_ff @(posedge i_clk) begin
        if (post_res) begin
            r_o_op    <= r_op;
            r_o_run   <= r_run;
            r_o_item  <= r_item;
            r_o_shown <= r_shown;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_in_operation  = r_o_op;
    assign o_is_running    = r_o_run;
    assign o_gain_selected = r_o_item;
    assign o_shown_value   = r_o_shown;
endmodule

>>> hw/rtl/pgm_div.sv
module pgm_div
    import pgm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [VW-1:0]    i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    // restoring divider, one quotient bit per cycle
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [VW-1:0]    r_div;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             qbit;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DVD_W-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> hw/rtl/pgm_mac.sv
module pgm_mac
    import pgm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clr,
    input  logic                    i_en,
    input  logic signed [VW-1:0]    i_a,
    input  logic signed [VW-1:0]    i_b,
    output logic signed [ACC_W-1:0] o_acc
);
    // product registered, then accumulated on the next cycle
    logic signed [2*VW-1:0]  r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_en && !i_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;
endmodule

>>> hw/rtl/pgm_chk.sv
module pgm_chk
    import pgm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_gain_selected,
    input logic signed [VW-1:0] o_shown_value
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_shown_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");

    a_item_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gain_selected != 2'd3)
        else $error("bad gain index");
endmodule

bind pid_controller_with_gain_menu_core pgm_chk u_pgm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_gain_selected (o_gain_selected),
    .o_shown_value   (o_shown_value)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pgm_pkg::*;

    // ---- DUT connections ----
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [VW-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_plus_pressed;
    logic                 i_minus_pressed;
    logic                 i_set_pressed;
    logic                 i_hold_pressed;
    logic signed [VW-1:0] i_measured_velocity;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_in_operation;
    logic                 o_is_running;
    logic [1:0]           o_gain_selected;
    logic signed [VW-1:0] o_shown_value;

    pid_controller_with_gain_menu_core dut (.*);

    // One button/velocity beat and one display beat.
    typedef struct {
        logic                 plus;
        logic                 minus;
        logic                 set;
        logic                 hold;
        logic signed [VW-1:0] vel;
    } button_beat_t;

    typedef struct {
        logic                 op;
        logic                 run;
        logic [1:0]           sel;
        logic signed [VW-1:0] shown;
    } panel_t;

    button_beat_t button_q[$];   // beats waiting to be driven
    panel_t       panel_due_q[$]; // display beats the controller owes us

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_stall;
    bit  in_taken;
    int  beats_sent;
    int  err_count;
    int  cycle_count;

    // Generator's view of the mode, so random sequences follow the menu flow.
    bit  gen_op;
    bit  gen_run;

    localparam longint VMAX_L  = 64'sd2147483647;
    localparam longint VMIN_L  = -64'sd2147483648;
    localparam int     TIMEOUT = 400000;

    // ---- predictor state ----
    logic signed [VW-1:0] set_point;
    logic [VW-1:0]        period_raw;
    bit                   ctl_op;
    bit                   ctl_run;
    logic [1:0]           cur_item;
    logic [GW-1:0]        gain_steps[3];
    longint               tustin_k[3];   // a, b, c
    longint               err_hist[3];
    longint               u_hist[3];

    function automatic longint clamp_word(longint x);
        if (x > VMAX_L) return VMAX_L;
        if (x < VMIN_L) return VMIN_L;
        return x;
    endfunction

    function automatic longint half_steps_value(logic [GW-1:0] h);
        return longint'(64'(h) << (FB - 1));
    endfunction

    // Tustin coefficients from the gains and the sample period.
    task automatic rebuild_tustin();
        logic [63:0] t;
        longint d, p, ki;
        t = 64'(period_raw);
        if (t == 0) t = 1;
        d  = longint'((64'(gain_steps[ITEM_KD]) << (2 * FB)) / t);
        p  = half_steps_value(gain_steps[ITEM_KP]);
        ki = longint'((64'(gain_steps[ITEM_KI]) * t) >> 2);
        tustin_k[0] = clamp_word(d + p + ki);
        tustin_k[1] = clamp_word(2 * ki - 2 * d);
        tustin_k[2] = clamp_word(d - p + ki);
    endtask

    task automatic wipe_history();
        for (int k = 0; k < 3; k++) begin
            err_hist[k] = 0;
            u_hist[k]   = 0;
        end
    endtask

    // Velocity-form PID step: u = a*e + b*e1 + c*e2 (>> F, floor) + u2.
    function automatic longint pid_effort();
        logic signed [127:0] acc;
        logic signed [127:0] ka, kb, kc, e0, e1, e2;
        ka = tustin_k[0];
        kb = tustin_k[1];
        kc = tustin_k[2];
        e0 = err_hist[0];
        e1 = err_hist[1];
        e2 = err_hist[2];
        acc = ka * e0 + kb * e1 + kc * e2;
        acc = (acc >>> FB) + 128'(u_hist[2]);
        if (acc > 128'(VMAX_L)) return VMAX_L;
        if (acc < 128'(VMIN_L)) return VMIN_L;
        return longint'(acc);
    endfunction

    // Advance the controller model by one accepted beat; queue the display it owes.
    task automatic advance_controller(button_beat_t b);
        longint tgt;
        longint shown;
        panel_t p;
        tgt = longint'(set_point);
        if (!ctl_op) begin
            if (b.hold) begin
                ctl_op  = 1;
                ctl_run = 0;
                rebuild_tustin();
                shown = tgt;
            end else if (b.set) begin
                cur_item = (cur_item == ITEM_KD) ? ITEM_KP : cur_item + 2'd1;
                shown = half_steps_value(gain_steps[cur_item]);
            end else begin
                if (b.plus) begin
                    if (gain_steps[cur_item] < GAIN_MAX) gain_steps[cur_item]++;
                end else if (b.minus) begin
                    if (gain_steps[cur_item] > 0) gain_steps[cur_item]--;
                end
                shown = half_steps_value(gain_steps[cur_item]);
            end
        end else if (!ctl_run) begin
            // standby rebuilds coefficients on every beat
            rebuild_tustin();
            if (b.hold) begin
                ctl_op   = 0;
                cur_item = ITEM_KP;
                wipe_history();
                shown = half_steps_value(gain_steps[ITEM_KP]);
            end else if (b.set) begin
                ctl_run = 1;
                shown = u_hist[0];
            end else begin
                shown = tgt;
            end
        end else begin
            if (b.hold) begin
                // running flag is left as is; re-entry from the menu clears it
                ctl_op   = 0;
                cur_item = ITEM_KP;
                wipe_history();
                shown = half_steps_value(gain_steps[ITEM_KP]);
            end else if (b.set) begin
                ctl_run = 0;
                wipe_history();
                shown = tgt;
            end else begin
                err_hist[2] = err_hist[1];
                err_hist[1] = err_hist[0];
                u_hist[2]   = u_hist[1];
                u_hist[1]   = u_hist[0];
                err_hist[0] = clamp_word(tgt - longint'(b.vel));
                u_hist[0]   = pid_effort();
                shown = u_hist[0];
            end
        end
        p.op    = ctl_op;
        p.run   = ctl_run;
        p.sel   = cur_item;
        p.shown = shown[VW-1:0];
        panel_due_q.push_back(p);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH @%0t %s: got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    // ---- clock ----
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- input driver: sample acceptance at rise, drive at fall ----
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            button_beat_t b;
            b.plus  = i_plus_pressed;
            b.minus = i_minus_pressed;
            b.set   = i_set_pressed;
            b.hold  = i_hold_pressed;
            b.vel   = i_measured_velocity;
            advance_controller(b);
            beats_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (button_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                button_beat_t b;
                b = button_q.pop_front();
                i_plus_pressed      <= b.plus;
                i_minus_pressed     <= b.minus;
                i_set_pressed       <= b.set;
                i_hold_pressed      <= b.hold;
                i_measured_velocity <= b.vel;
                i_in_valid          <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---- output side: random backpressure, long stall on request ----
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_ready <= !recv_stall && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (panel_due_q.size() == 0) begin
                report("unexpected beat", o_shown_value, 0);
            end else begin
                panel_t w;
                w = panel_due_q.pop_front();
                if (o_in_operation !== w.op)   report("in_operation", o_in_operation, w.op);
                if (o_is_running !== w.run)    report("is_running", o_is_running, w.run);
                if (o_gain_selected !== w.sel) report("gain_selected", o_gain_selected, w.sel);
                if (o_shown_value !== w.shown) report("shown_value", o_shown_value, w.shown);
            end
        end
    end

    // Mid-run, hold the output off long enough that the block backs up.
    initial begin
        recv_stall = 0;
        wait (beats_sent >= 350);
        @(negedge i_clk);
        recv_stall = 1;
        repeat (300) @(negedge i_clk);
        recv_stall = 0;
    end

    // ---- stimulus helpers ----
    task automatic queue_beat(bit p, bit m, bit s, bit h, logic [VW-1:0] v);
        button_beat_t b;
        b.plus = p; b.minus = m; b.set = s; b.hold = h; b.vel = v;
        button_q.push_back(b);
        // track mode for the generator
        if (!gen_op) begin
            if (h) begin gen_op = 1; gen_run = 0; end
        end else if (!gen_run) begin
            if (h) gen_op = 0;
            else if (s) gen_run = 1;
        end else begin
            if (h) gen_op = 0;
            else if (s) gen_run = 0;
        end
    endtask

    task automatic write_reg(logic idx, logic [VW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        if (idx == REG_TARGET) set_point = val;
        else                   period_raw = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (button_q.size() == 0 && !i_in_valid && panel_due_q.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [VW-1:0] pick_velocity();
        int r;
        r = $urandom_range(99);
        if (r < 35) return set_point + VW'($signed($urandom_range(8191)) - 4096);
        if (r < 45) return (r[0]) ? 32'h7FFFFFFF : 32'h80000000;
        return $urandom;
    endfunction

    // Random beats, mostly well-formed menu -> standby -> run sequences.
    task automatic queue_random(int n);
        bit plus_bias;
        plus_bias = $urandom_range(1);
        for (int k = 0; k < n; k++) begin
            int r;
            bit p, m;
            r = $urandom_range(99);
            p = $urandom_range(1);
            m = $urandom_range(1);
            if (!gen_op) begin
                if (r < 4) begin
                    queue_beat(p, m, $urandom_range(1), 1, $urandom);
                    plus_bias = $urandom_range(1);
                end else if (r < 14) begin
                    queue_beat(p, m, 1, 0, $urandom);
                end else begin
                    p = ($urandom_range(99) < (plus_bias ? 80 : 20));
                    m = $urandom_range(1);
                    queue_beat(p, m, 0, 0, $urandom);
                end
            end else if (!gen_run) begin
                if (r < 15)      queue_beat(p, m, $urandom_range(1), 1, $urandom);
                else if (r < 75) queue_beat(p, m, 1, 0, $urandom);
                else             queue_beat(p, m, 0, 0, $urandom);
            end else begin
                if (r < 3)       queue_beat(p, m, $urandom_range(1), 1, pick_velocity());
                else if (r < 6)  queue_beat(p, m, 1, 0, pick_velocity());
                else             queue_beat(p, m, 0, 0, pick_velocity());
            end
        end
    endtask

    // ---- main sequence ----
    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_TARGET;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_plus_pressed = 0;
        i_minus_pressed = 0;
        i_set_pressed = 0;
        i_hold_pressed = 0;
        i_measured_velocity = '0;
        i_out_ready = 0;
        in_taken = 0;
        beats_sent = 0;
        err_count = 0;
        cycle_count = 0;
        send_idle_pct = 17;
        recv_idle_pct = 68;
        gen_op = 0;
        gen_run = 0;

        // predictor reset state
        set_point  = '0;
        period_raw = PERIOD_RESET;
        ctl_op = 0;
        ctl_run = 0;
        cur_item = ITEM_KP;
        for (int k = 0; k < 3; k++) begin
            gain_steps[k] = GAIN_RESET;
            tustin_k[k] = 0;
        end
        wipe_history();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: gain clamps, menu wrap, every mode change, velocity extremes
        write_reg(REG_TARGET, 32'h0003_8000);
        write_reg(REG_PERIOD, PERIOD_RESET);
        queue_beat(0, 1, 0, 0, 0);              // kp 1.0 -> 0.5
        queue_beat(0, 1, 0, 0, 0);              // -> 0
        queue_beat(0, 1, 0, 0, 0);              // stays at 0
        queue_beat(1, 1, 0, 0, 0);              // plus wins over minus
        queue_beat(0, 0, 1, 0, 0);              // ki
        queue_beat(1, 0, 0, 0, 0);
        queue_beat(0, 0, 1, 0, 0);              // kd
        queue_beat(0, 0, 1, 0, 0);              // wraps to kp
        queue_beat(0, 0, 1, 1, 0);              // hold beats set -> standby
        queue_beat(0, 0, 0, 0, 32'h1234_5678);  // standby, nothing pressed
        queue_beat(1, 1, 0, 0, 0);              // standby ignores plus/minus
        queue_beat(0, 0, 1, 0, 0);              // run
        queue_beat(0, 0, 0, 0, 32'h7FFF_FFFF);
        queue_beat(1, 1, 0, 0, 32'h8000_0000);  // error saturates high
        queue_beat(0, 0, 0, 0, 32'h0000_0000);
        queue_beat(0, 0, 0, 0, 32'hFFFF_0000);
        queue_beat(0, 0, 1, 0, 0);              // stop, history cleared
        queue_beat(0, 0, 1, 0, 0);              // run again
        queue_beat(0, 0, 0, 0, 32'h0001_0000);
        queue_beat(0, 0, 0, 1, 0);              // hold from running -> menu
        queue_beat(0, 0, 0, 1, 0);              // -> standby
        queue_beat(0, 0, 1, 1, 0);              // hold from standby -> menu
        drain();

        // random phase 1: sender idles rarely, receiver often
        write_reg(REG_TARGET, 32'h7FFF_FFFF);
        write_reg(REG_PERIOD, 32'h0000_0001);
        queue_random(260);
        drain();

        // random phase 2: roles swapped
        send_idle_pct = 68;
        recv_idle_pct = 17;
        write_reg(REG_TARGET, 32'h8000_0000);
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        queue_random(260);
        drain();

        // random phase 3: full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TARGET, VW'($signed($urandom_range(1 << 20)) - (1 << 19)));
        write_reg(REG_PERIOD, $urandom_range(65535, 1));
        queue_random(260);
        drain();

        repeat (60) @(negedge i_clk);
        if (err_count == 0 && panel_due_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pgm_pkg.sv
hw/rtl/pgm_div.sv
hw/rtl/pgm_mac.sv
hw/rtl/pid_controller_with_gain_menu_core.sv
hw/rtl/pgm_chk.sv
dv/tb_top.sv
